### rtl/ppot_pkg.sv
// Shared types and constants for the physical page owner table.
`default_nettype none
package ppot_pkg;

    localparam int N_FRAMES   = 512;
    localparam int PN_W       = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
    localparam int PAGE_SHIFT = 12;
    localparam int OP_W       = 3;
    localparam int OWN_W      = 5;
    localparam int ADDR_W     = 22;
    localparam int APN_W      = ADDR_W - PAGE_SHIFT;
    localparam int STAT_W     = 3;
    localparam int PADDR_W    = 21;
    localparam int CNT_W      = 10;
    localparam int REFS_W     = 7;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [OWN_W-1:0]  OWN_FREE = '0;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_ASSIGN  = 3'd1,
        OP_ADDREF  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_COUNT   = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_RANGE      = 3'd2,
        ST_IN_USE     = 3'd3,
        ST_NONE_FREE  = 3'd4,
        ST_SATURATED  = 3'd5
    } t_status;

    typedef struct packed {
        logic [OWN_W-1:0]  owner;
        logic [REFS_W-1:0] refs;
    } t_entry;

endpackage
`default_nettype wire

### rtl/physical_page_owner_table_top.sv
// Physical page owner table: owner code and reference count per page in one RAM.
// Reset: a clearing pass writes every entry free, input stalled.
// Assign and add-ref: one RAM read-modify-write of the addressed entry; the RAM is
// not read for an alignment or range reject or for unused op codes.
// Allocate, release and count: one RAM entry per cycle, scanning up to all N_FRAMES entries.
// Throughput: one item at a time; the next beat is taken once the result is registered.
`default_nettype none
module physical_page_owner_table_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ppot_pkg::OP_W-1:0]      i_op,
    input  logic signed [ppot_pkg::OWN_W-1:0] i_owner_id,
    input  logic [ppot_pkg::ADDR_W-1:0]    i_address,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ppot_pkg::STAT_W-1:0]    o_status,
    output logic [ppot_pkg::PADDR_W-1:0]   o_page_address,
    output logic [ppot_pkg::CNT_W-1:0]     o_page_count
);
    import ppot_pkg::*;

    localparam logic [PN_W-1:0] PN_LAST = PN_W'(N_FRAMES - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_DONE} t_state;

    t_entry mem [N_FRAMES];
    t_entry r_rd_data;

    t_state              r_state, n_state;
    logic [PN_W-1:0]     r_ptr, n_ptr;
    logic                r_issue, n_issue;
    logic                r_rd_vld, n_rd_vld;
    logic [PN_W-1:0]     r_rd_pn, n_rd_pn;
    t_op                 r_op, n_op;
    logic [OWN_W-1:0]    r_who, n_who;
    t_status             r_st, n_st;
    logic [PADDR_W-1:0]  r_pa, n_pa;
    logic [CNT_W-1:0]    r_pc, n_pc;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_o_status, n_o_status;
    logic [PADDR_W-1:0]  r_o_pa, n_o_pa;
    logic [CNT_W-1:0]    r_o_pc, n_o_pc;

    logic                mem_we, mem_re;
    logic [PN_W-1:0]     mem_wa, mem_ra;
    t_entry              mem_wd;

    logic [APN_W-1:0]    addr_pn;
    logic                in_range;
    logic                own_match;
    logic [REFS_W-1:0]   rel_refs;

    assign addr_pn   = i_address[ADDR_W-1:PAGE_SHIFT];
    assign in_range  = (32'(addr_pn) < N_FRAMES);
    assign own_match = (r_rd_data.owner == r_who);
    assign rel_refs  = r_rd_data.refs - REFS_W'(r_rd_data.refs != '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_issue     = r_issue;
        n_rd_vld    = r_rd_vld;
        n_rd_pn     = r_rd_pn;
        n_op        = r_op;
        n_who       = r_who;
        n_st        = r_st;
        n_pa        = r_pa;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_pa      = r_o_pa;
        n_o_pc      = r_o_pc;
        mem_we      = 1'b0;
        mem_wa      = r_rd_pn;
        mem_wd      = '0;
        mem_re      = 1'b0;
        mem_ra      = r_ptr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
                if (r_ptr == PN_LAST) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + PN_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = t_op'(i_op);
                    n_who = i_owner_id;
                    n_st  = ST_OK;
                    n_pa  = '0;
                    n_pc  = '0;
                    unique case (t_op'(i_op))
                        OP_ALLOC, OP_RELEASE, OP_COUNT: begin
                            mem_re   = 1'b1;
                            mem_ra   = '0;
                            n_rd_vld = 1'b1;
                            n_rd_pn  = '0;
                            n_ptr    = PN_W'(1);
                            n_issue  = 1'b1;
                            n_state  = S_RUN;
                        end
                        OP_ASSIGN: begin
                            if (i_address[PAGE_SHIFT-1:0] != '0) begin
                                n_st    = ST_MISALIGNED;
                                n_state = S_DONE;
                            end else if (!in_range) begin
                                n_st    = ST_RANGE;
                                n_state = S_DONE;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = PN_W'(addr_pn);
                                n_rd_vld = 1'b1;
                                n_rd_pn  = PN_W'(addr_pn);
                                n_issue  = 1'b0;
                                n_state  = S_RUN;
                            end
                        end
                        OP_ADDREF: begin
                            if (!in_range) begin
                                n_st    = ST_RANGE;
                                n_state = S_DONE;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = PN_W'(addr_pn);
                                n_rd_vld = 1'b1;
                                n_rd_pn  = PN_W'(addr_pn);
                                n_issue  = 1'b0;
                                n_state  = S_RUN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                // read the next entry while the previous one is written back
                if (r_issue) begin
                    mem_re   = 1'b1;
                    mem_ra   = r_ptr;
                    n_rd_vld = 1'b1;
                    n_rd_pn  = r_ptr;
                    if (r_ptr == PN_LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + PN_W'(1);
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end

                if (r_rd_vld) begin
                    unique case (r_op)
                        OP_ALLOC: begin
                            if (r_rd_data.owner == OWN_FREE && r_rd_data.refs == '0) begin
                                mem_we       = 1'b1;
                                mem_wd.owner = r_who;
                                mem_wd.refs  = REFS_W'(1);
                                n_pa         = PADDR_W'({r_rd_pn, {PAGE_SHIFT{1'b0}}});
                                n_st         = ST_OK;
                                n_issue      = 1'b0;
                                n_rd_vld     = 1'b0;
                                n_state      = S_DONE;
                            end else if (!r_issue) begin
                                n_st    = ST_NONE_FREE;
                                n_state = S_DONE;
                            end
                        end
                        OP_ASSIGN: begin
                            if (r_rd_data.refs != '0) begin
                                n_st = ST_IN_USE;
                            end else begin
                                mem_we       = 1'b1;
                                mem_wd.owner = r_who;
                                mem_wd.refs  = REFS_W'(1);
                            end
                            n_state = S_DONE;
                        end
                        OP_ADDREF: begin
                            if (r_rd_data.refs == REFS_MAX) begin
                                n_st = ST_SATURATED;
                            end else begin
                                mem_we       = 1'b1;
                                mem_wd.owner = r_rd_data.owner;
                                mem_wd.refs  = r_rd_data.refs + REFS_W'(1);
                            end
                            n_state = S_DONE;
                        end
                        OP_RELEASE: begin
                            if (own_match) begin
                                mem_we       = 1'b1;
                                mem_wd.refs  = rel_refs;
                                mem_wd.owner = (rel_refs == '0) ? OWN_FREE : r_rd_data.owner;
                            end
                            if (!r_issue) begin
                                n_state = S_DONE;
                            end
                        end
                        OP_COUNT: begin
                            if (own_match && r_pc != CNT_MAX) begin
                                n_pc = r_pc + CNT_W'(1);
                            end
                            if (!r_issue) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_pa      = r_pa;
                    n_o_pc      = r_pc;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
        r_rd_pn    <= n_rd_pn;
        r_op       <= n_op;
        r_who      <= n_who;
        r_st       <= n_st;
        r_pa       <= n_pa;
        r_pc       <= n_pc;
        r_o_status <= n_o_status;
        r_o_pa     <= n_o_pa;
        r_o_pc     <= n_o_pc;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_page_address = r_o_pa;
    assign o_page_count   = r_o_pc;

endmodule
`default_nettype wire
